@@ hdl/sbt_pkg.sv @@
// Shared types and constants of the source byte tokenizer.
// Depends on nothing; sbt_scanner, sbt_emitter and source_byte_tokenizer import it.
package sbt_pkg;

	typedef enum logic [3:0] {
		MODE_IDLE,
		MODE_OPER,
		MODE_COMMENT,
		MODE_NUMBER,
		MODE_NUMDOT,
		MODE_IDENT,
		MODE_STRING,
		MODE_STRESC,
		MODE_ERROR
	} mode_t;

	typedef logic [5:0] kind_t;
	typedef logic [2:0] err_t;

	localparam kind_t K_COMMA        = 6'd0;
	localparam kind_t K_TILDE        = 6'd1;
	localparam kind_t K_BANG_EQ      = 6'd2;
	localparam kind_t K_BANG         = 6'd3;
	localparam kind_t K_AT           = 6'd4;
	localparam kind_t K_PLUS         = 6'd5;
	localparam kind_t K_MINUS        = 6'd6;
	localparam kind_t K_QUESTION     = 6'd7;
	localparam kind_t K_MUL          = 6'd8;
	localparam kind_t K_DIV          = 6'd9;
	localparam kind_t K_EQUAL        = 6'd10;
	localparam kind_t K_MOD          = 6'd11;
	localparam kind_t K_SEMI         = 6'd12;
	localparam kind_t K_CONST_ASSIGN = 6'd13;
	localparam kind_t K_MUT_ASSIGN   = 6'd14;
	localparam kind_t K_COLON        = 6'd15;
	localparam kind_t K_AND          = 6'd16;
	localparam kind_t K_CONCAT       = 6'd17;
	localparam kind_t K_STRING       = 6'd18;
	localparam kind_t K_RCURLY       = 6'd19;
	localparam kind_t K_LCURLY       = 6'd20;
	localparam kind_t K_RPAREN       = 6'd21;
	localparam kind_t K_LPAREN       = 6'd22;
	localparam kind_t K_LESS_EQ      = 6'd23;
	localparam kind_t K_LESS         = 6'd24;
	localparam kind_t K_GREATER_EQ   = 6'd25;
	localparam kind_t K_GREATER      = 6'd26;
	localparam kind_t K_FLOAT        = 6'd27;
	localparam kind_t K_INTEGER      = 6'd28;
	localparam kind_t K_KW_FIRST     = 6'd29;
	localparam kind_t K_IDENT        = 6'd40;
	localparam kind_t K_EOF          = 6'd41;
	localparam kind_t K_ERROR        = 6'd42;

	localparam err_t ERR_NONE   = 3'd0;
	localparam err_t ERR_TOKEN  = 3'd1;
	localparam err_t ERR_STRING = 3'd2;
	localparam err_t ERR_FLOAT  = 3'd3;
	localparam err_t ERR_COLON  = 3'd4;

	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;

	localparam int KW_COUNT = 11;

	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		64'h6966, 64'h6C6574, 64'h626567696E, 64'h656E64, 64'h72657475726E,
		64'h74727565, 64'h66616C7365, 64'h6E696C, 64'h7468656E,
		64'h656C7365, 64'h656C6966
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd2, 4'd3, 4'd5, 4'd3, 4'd6, 4'd4, 4'd5, 4'd3, 4'd4, 4'd4, 4'd4
	};

endpackage

@@ hdl/sbt_byte_if.sv @@
// Input channel of the tokenizer: one source byte per word.
// Depends on nothing.
interface sbt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	logic       final_byte;

	modport source(output valid, source_byte, final_byte, input ready);
	modport sink(input valid, source_byte, final_byte, output ready);
endinterface

@@ hdl/sbt_token_if.sv @@
// Output channel of the tokenizer: one token or error report per word.
// Depends on nothing.
interface sbt_token_if #(
	parameter int POSITION_BITS = 16
);
	logic                     valid;
	logic                     ready;
	logic [5:0]               token_kind;
	logic [POSITION_BITS-1:0] start_line;
	logic [POSITION_BITS-1:0] start_column;
	logic [POSITION_BITS-1:0] lexeme_length;
	logic [2:0]               error_code;
	logic                     run_end;

	modport source(output valid, token_kind, start_line, start_column, lexeme_length,
		error_code, run_end, input ready);
	modport sink(input valid, token_kind, start_line, start_column, lexeme_length,
		error_code, run_end, output ready);
endinterface

@@ hdl/sbt_scanner.sv @@
// Front part: accepts source bytes, runs the scanner state and builds the
// group of up to three results each byte causes. Depends on sbt_pkg, sbt_byte_if.
module sbt_scanner #(
	parameter int POSITION_BITS = 16,
	parameter int KEYWORD_CHARS = 6,
	parameter int ENTRY_BITS    = 2 + 3 * (9 + 3 * 16)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sbt_byte_if.sink              src,
	input  logic                  full,
	output logic                  push,
	output logic [ENTRY_BITS-1:0] entry
);
	import sbt_pkg::*;

	localparam int P  = POSITION_BITS;
	localparam int WB = 8 * KEYWORD_CHARS;

	typedef struct packed {
		kind_t        kind;
		logic [P-1:0] line;
		logic [P-1:0] col;
		logic [P-1:0] len;
		err_t         err;
	} tok_t;

	mode_t          mode_q;
	logic [P-1:0]   line_q, col_q, tsl_q, tsc_q, len_q;
	logic [7:0]     held_q;
	logic [WB-1:0]  win_q;
	logic           pt_q;

	mode_t          m;
	logic [P-1:0]   ln, cl, tl, tc, lv;
	logic [7:0]     hb;
	logic [WB-1:0]  w;
	logic           pt;
	logic [1:0]     n;
	tok_t           r [3];
	logic           redo;
	logic [6:0]     sk;
	logic [7:0]     b;
	logic           accept;

	function automatic logic [P-1:0] sat(input logic [P-1:0] a, input logic [P-1:0] c);
		logic [P:0] s;
		s = {1'b0, a} + {1'b0, c};
		return s[P] ? {P{1'b1}} : s[P-1:0];
	endfunction

	function automatic logic [P-1:0] sat_inc2(input logic [P-1:0] a, input logic [P-1:0] c);
		logic [P+1:0] s;
		s = {2'b00, a} + {2'b00, c} + (P+2)'(1);
		return (s[P+1:P] != 2'b00) ? {P{1'b1}} : s[P-1:0];
	endfunction

	function automatic tok_t mk(input kind_t k, input logic [P-1:0] l, input logic [P-1:0] c,
		input logic [P-1:0] len, input err_t e);
		tok_t t;
		t.kind = k;
		t.line = l;
		t.col  = c;
		t.len  = len;
		t.err  = e;
		return t;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic [6:0] single_kind(input logic [7:0] c);
		logic [6:0] o;
		case (c)
			",": o = {1'b1, K_COMMA};
			"~": o = {1'b1, K_TILDE};
			"@": o = {1'b1, K_AT};
			"+": o = {1'b1, K_PLUS};
			"?": o = {1'b1, K_QUESTION};
			"*": o = {1'b1, K_MUL};
			"/": o = {1'b1, K_DIV};
			"%": o = {1'b1, K_MOD};
			";": o = {1'b1, K_SEMI};
			"}": o = {1'b1, K_RCURLY};
			"{": o = {1'b1, K_LCURLY};
			")": o = {1'b1, K_RPAREN};
			"(": o = {1'b1, K_LPAREN};
			default: o = 7'd0;
		endcase
		return o;
	endfunction

	function automatic logic [6:0] held_kind(input logic [7:0] c);
		logic [6:0] o;
		case (c)
			"!": o = {1'b1, K_BANG};
			"-": o = {1'b1, K_MINUS};
			"&": o = {1'b1, K_CONCAT};
			"<": o = {1'b1, K_LESS};
			">": o = {1'b1, K_GREATER};
			":": o = {1'b1, K_COLON};
			default: o = 7'd0;
		endcase
		return o;
	endfunction

	function automatic logic [6:0] pair_kind(input logic [7:0] f, input logic [7:0] s);
		logic [6:0] o;
		o = 7'd0;
		if (f == "!" && s == "=") o = {1'b1, K_BANG_EQ};
		if (f == "=" && s == "=") o = {1'b1, K_EQUAL};
		if (f == ":" && s == ":") o = {1'b1, K_CONST_ASSIGN};
		if (f == ":" && s == "=") o = {1'b1, K_MUT_ASSIGN};
		if (f == "&" && s == "&") o = {1'b1, K_AND};
		if (f == "<" && s == "=") o = {1'b1, K_LESS_EQ};
		if (f == ">" && s == "=") o = {1'b1, K_GREATER_EQ};
		return o;
	endfunction

	function automatic kind_t ident_kind(input logic [WB-1:0] win, input logic [P-1:0] len);
		kind_t      k;
		logic [63:0] mask;
		logic [63:0] w64;
		k = K_IDENT;
		w64 = 64'(win);
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			mask = (64'd1 << (8 * KW_LEN[i])) - 64'd1;
			if (len == P'(KW_LEN[i]) && (w64 & mask) == KW_TEXT[i])
				k = K_KW_FIRST + 6'(i);
		end
		return k;
	endfunction

	assign b         = src.source_byte;
	assign src.ready = !full;
	assign accept    = src.valid && !full;

	always_comb begin
		m = mode_q;
		ln = line_q;
		cl = col_q;
		tl = tsl_q;
		tc = tsc_q;
		lv = len_q;
		hb = held_q;
		w = win_q;
		pt = pt_q;
		n = 2'd0;
		r[0] = '0;
		r[1] = '0;
		r[2] = '0;
		redo = 1'b0;
		sk = 7'd0;

		case (m)
			MODE_IDLE: redo = 1'b1;
			MODE_OPER: begin
				sk = pair_kind(hb, b);
				if (sk[6]) begin
					lv = P'(2);
					r[n] = mk(sk[5:0], tl, tc, lv, ERR_NONE);
					n = n + 2'd1;
					cl = sat(tc, lv);
					m = MODE_IDLE;
				end else if (hb == "-" && b == "-") begin
					m = MODE_COMMENT;
				end else begin
					sk = held_kind(hb);
					if (sk[6]) begin
						r[n] = mk(sk[5:0], tl, tc, lv, ERR_NONE);
						n = n + 2'd1;
						cl = sat(tc, lv);
						m = MODE_IDLE;
						redo = 1'b1;
					end else begin
						r[n] = mk(K_ERROR, tl, tc, '0, ERR_TOKEN);
						n = n + 2'd1;
						m = MODE_ERROR;
					end
				end
			end
			MODE_COMMENT: begin
				if (b == CH_LF) begin
					ln = sat(ln, P'(1));
					cl = P'(1);
					m = MODE_IDLE;
				end
			end
			MODE_NUMBER: begin
				if (is_digit(b) || b == "_") begin
					lv = sat(lv, P'(1));
				end else if (b == ".") begin
					if (pt) begin
						r[n] = mk(K_ERROR, tl, sat(tc, lv), '0, ERR_FLOAT);
						n = n + 2'd1;
						m = MODE_ERROR;
					end else begin
						lv = sat(lv, P'(1));
						pt = 1'b1;
						m = MODE_NUMDOT;
					end
				end else begin
					r[n] = mk(pt ? K_FLOAT : K_INTEGER, tl, tc, lv, ERR_NONE);
					n = n + 2'd1;
					cl = sat(tc, lv);
					m = MODE_IDLE;
					redo = 1'b1;
				end
			end
			MODE_NUMDOT: begin
				if (is_digit(b)) begin
					lv = sat(lv, P'(1));
					m = MODE_NUMBER;
				end else begin
					r[n] = mk(K_ERROR, tl, sat(tc, lv - P'(1)), '0, ERR_FLOAT);
					n = n + 2'd1;
					m = MODE_ERROR;
				end
			end
			MODE_IDENT: begin
				if (is_alpha(b) || is_digit(b) || b == "_") begin
					lv = sat(lv, P'(1));
					w = {w[WB-9:0], b};
				end else begin
					r[n] = mk(ident_kind(w, lv), tl, tc, lv, ERR_NONE);
					n = n + 2'd1;
					cl = sat(tc, lv);
					m = MODE_IDLE;
					redo = 1'b1;
				end
			end
			MODE_STRING: begin
				lv = sat(lv, P'(1));
				if (b == "\\") begin
					m = MODE_STRESC;
				end else if (b == "\"") begin
					r[n] = mk(K_STRING, tl, tc, lv, ERR_NONE);
					n = n + 2'd1;
					cl = sat(tc, lv);
					m = MODE_IDLE;
				end
			end
			MODE_STRESC: begin
				lv = sat(lv, P'(1));
				if (b == "n" || b == "t" || b == "\"" || b == "\\") begin
					m = MODE_STRING;
				end else begin
					r[n] = mk(K_ERROR, tl, sat(tc, lv), '0, ERR_STRING);
					n = n + 2'd1;
					m = MODE_ERROR;
				end
			end
			default: m = MODE_ERROR;
		endcase

		if (redo) begin
			tl = ln;
			tc = cl;
			lv = P'(1);
			sk = single_kind(b);
			if (sk[6]) begin
				r[n] = mk(sk[5:0], tl, tc, lv, ERR_NONE);
				n = n + 2'd1;
				cl = sat(tc, lv);
				m = MODE_IDLE;
			end else if (b == "!" || b == "-" || b == "=" || b == ":" || b == "&" ||
				b == "<" || b == ">") begin
				hb = b;
				m = MODE_OPER;
			end else if (b == "\"") begin
				m = MODE_STRING;
			end else if (b == CH_LF) begin
				ln = sat(ln, P'(1));
				cl = P'(1);
			end else if (b == " " || b == CH_TAB) begin
				cl = sat(cl, P'(1));
			end else if (is_digit(b)) begin
				pt = 1'b0;
				m = MODE_NUMBER;
			end else if (is_alpha(b) || b == "_") begin
				w = WB'(b);
				m = MODE_IDENT;
			end else begin
				r[n] = mk(K_ERROR, tl, cl, '0, ERR_TOKEN);
				n = n + 2'd1;
				m = MODE_ERROR;
			end
		end

		if (src.final_byte) begin
			case (m)
				MODE_OPER: begin
					sk = held_kind(hb);
					if (hb == ":") begin
						r[n] = mk(K_ERROR, tl, tc, '0, ERR_COLON);
						n = n + 2'd1;
					end else if (sk[6]) begin
						r[n] = mk(sk[5:0], tl, tc, lv, ERR_NONE);
						n = n + 2'd1;
					end else begin
						r[n] = mk(K_ERROR, tl, tc, '0, ERR_TOKEN);
						n = n + 2'd1;
					end
				end
				MODE_NUMBER: begin
					r[n] = mk(pt ? K_FLOAT : K_INTEGER, tl, tc, lv, ERR_NONE);
					n = n + 2'd1;
				end
				MODE_NUMDOT: begin
					r[n] = mk(K_ERROR, tl, sat(tc, lv - P'(1)), '0, ERR_FLOAT);
					n = n + 2'd1;
				end
				MODE_IDENT: begin
					r[n] = mk(ident_kind(w, lv), tl, tc, lv, ERR_NONE);
					n = n + 2'd1;
				end
				MODE_STRING, MODE_STRESC: begin
					r[n] = mk(K_ERROR, tl, sat_inc2(tc, lv), '0, ERR_STRING);
					n = n + 2'd1;
				end
				default: ;
			endcase
			r[n] = mk(K_EOF, P'(1), P'(1), '0, ERR_NONE);
			n = n + 2'd1;
			m = MODE_IDLE;
			ln = P'(1);
			cl = P'(1);
			tl = P'(1);
			tc = P'(1);
			lv = '0;
			hb = '0;
			w = '0;
			pt = 1'b0;
		end
	end

	assign push  = accept && n != 2'd0;
	assign entry = {n, r[2], r[1], r[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			line_q <= P'(1);
			col_q  <= P'(1);
			tsl_q  <= P'(1);
			tsc_q  <= P'(1);
			len_q  <= '0;
			held_q <= '0;
			win_q  <= '0;
			pt_q   <= 1'b0;
		end else if (accept) begin
			mode_q <= m;
			line_q <= ln;
			col_q  <= cl;
			tsl_q  <= tl;
			tsc_q  <= tc;
			len_q  <= lv;
			held_q <= hb;
			win_q  <= w;
			pt_q   <= pt;
		end
	end
endmodule

@@ hdl/sbt_queue.sv @@
// Short queue of result groups between the scanner and the emitter.
// Depends on nothing.
module sbt_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign valid   = cnt_q != '0;
	assign rdata   = mem_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (do_pop)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end
endmodule

@@ hdl/sbt_emitter.sv @@
// Back part: takes one result group from the queue and sends its results
// one word at a time, marking the last. Depends on sbt_pkg, sbt_token_if.
module sbt_emitter #(
	parameter int POSITION_BITS = 16,
	parameter int ENTRY_BITS    = 2 + 3 * (9 + 3 * 16)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  qvalid,
	input  logic [ENTRY_BITS-1:0] qdata,
	output logic                  pop,
	sbt_token_if.source           tok
);
	import sbt_pkg::*;

	localparam int P = POSITION_BITS;

	typedef struct packed {
		kind_t        kind;
		logic [P-1:0] line;
		logic [P-1:0] col;
		logic [P-1:0] len;
		err_t         err;
	} tok_t;

	typedef struct packed {
		logic [1:0] cnt;
		tok_t       r2;
		tok_t       r1;
		tok_t       r0;
	} group_t;

	group_t     hold_q;
	logic       hv_q;
	logic [1:0] idx_q;
	logic       last;
	tok_t       cur;

	assign last = idx_q == hold_q.cnt - 2'd1;
	assign pop  = qvalid && (!hv_q || (tok.ready && last));

	always_comb begin
		case (idx_q)
			2'd0: cur = hold_q.r0;
			2'd1: cur = hold_q.r1;
			default: cur = hold_q.r2;
		endcase
	end

	assign tok.valid         = hv_q;
	assign tok.token_kind    = cur.kind;
	assign tok.start_line    = cur.line;
	assign tok.start_column  = cur.col;
	assign tok.lexeme_length = cur.len;
	assign tok.error_code    = cur.err;
	assign tok.run_end       = last;

	always_ff @(posedge clk) begin
		if (pop)
			hold_q <= group_t'(qdata);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q  <= 1'b0;
			idx_q <= '0;
		end else if (pop) begin
			hv_q  <= 1'b1;
			idx_q <= '0;
		end else if (hv_q && tok.ready) begin
			if (last)
				hv_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end
endmodule

@@ hdl/source_byte_tokenizer.sv @@
// Top level of the source byte tokenizer: scanner, group queue and emitter.
// Depends on sbt_pkg, sbt_byte_if, sbt_token_if, sbt_scanner, sbt_queue, sbt_emitter.
//
//   channel  dir  word                      handshake
//   src      in   source_byte, final_byte   valid/ready
//   tok      out  one token or error        valid/ready, run_end marks last of a byte
//
// One source byte is accepted per cycle while the two-entry group queue has room.
// The emitter sends the k results of a byte one result per cycle while tok.ready is high.
// Reset leaves the scanner at line 1, column 1, between tokens, with the queue empty.
// A stalled output fills the queue and then holds src.ready low.
module source_byte_tokenizer #(
	parameter int POSITION_BITS = 16,
	parameter int KEYWORD_CHARS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	sbt_byte_if.sink    src,
	sbt_token_if.source tok
);
	import sbt_pkg::*;

	localparam int ENTRY_BITS  = 2 + 3 * ($bits(kind_t) + $bits(err_t) + 3 * POSITION_BITS);
	localparam int QUEUE_DEPTH = 2;

	logic                  push, full, qvalid, pop;
	logic [ENTRY_BITS-1:0] wdata, rdata;

	sbt_scanner #(
		.POSITION_BITS(POSITION_BITS),
		.KEYWORD_CHARS(KEYWORD_CHARS),
		.ENTRY_BITS(ENTRY_BITS)
	) u_scanner (
		.clk(clk),
		.arst_n(arst_n),
		.src(src),
		.full(full),
		.push(push),
		.entry(wdata)
	);

	sbt_queue #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(wdata),
		.full(full),
		.pop(pop),
		.valid(qvalid),
		.rdata(rdata)
	);

	sbt_emitter #(
		.POSITION_BITS(POSITION_BITS),
		.ENTRY_BITS(ENTRY_BITS)
	) u_emitter (
		.clk(clk),
		.arst_n(arst_n),
		.qvalid(qvalid),
		.qdata(rdata),
		.pop(pop),
		.tok(tok)
	);
endmodule
